// File: rtl/nbm_pkg.sv
// ----------------------------------------------------------------------------
// nbm_pkg
// Shared types, constants and cell lookup functions of the neighborhood
// template best match block.
// ----------------------------------------------------------------------------
package nbm_pkg;

    localparam int CELL_COUNT = 27;
    localparam int CODE_W     = 4;
    localparam int PRES_W     = 2;
    localparam int LEVEL_W    = 8;
    localparam int GAIN_W     = 6;
    localparam int CNT_W      = 5;
    localparam int CELLS_LO_W = 56;
    localparam int CELLS_HI_W = 52;
    localparam int CELLS_W    = CELLS_LO_W + CELLS_HI_W;
    localparam int PLANE_W    = CELL_COUNT * PRES_W;
    localparam int INDEX_W    = 8;

    localparam int CFG_ADDR_W = 8;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_ADDR_W-1:0] CFG_SELECT_MODE = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_LEVEL_SPLIT = 8'd1;

    localparam logic [1:0] MODE_LEVEL  = 2'd0;
    localparam logic [1:0] MODE_TARGET = 2'd1;
    localparam logic [1:0] MODE_TRAIN  = 2'd2;

    localparam logic [1:0]         SELECT_MODE_RESET = MODE_TARGET;
    localparam logic [LEVEL_W-1:0] LEVEL_SPLIT_RESET = 8'd10;

    typedef struct packed {
        logic                      match;
        logic signed [GAIN_W-1:0]  gain;
        logic [LEVEL_W-1:0]        level;
        logic                      last;
    } eval_t;

    function automatic logic cell_pass(logic [CODE_W-1:0] code, logic [PRES_W-1:0] pres);
        logic [3:0] row;
        begin
            case (code)
                4'd0:    row = 4'b1001;
                4'd3:    row = 4'b0010;
                4'd5:    row = 4'b0001;
                4'd6:    row = 4'b0010;
                4'd7:    row = 4'b0010;
                4'd8:    row = 4'b1111;
                default: row = 4'b0000;
            endcase
            return row[pres];
        end
    endfunction

    function automatic logic cell_gain_up(logic [CODE_W-1:0] code, logic [PRES_W-1:0] targ);
        return (code == 4'd5) && (targ == 2'd0);
    endfunction

    function automatic logic cell_gain_down(logic [CODE_W-1:0] code, logic [PRES_W-1:0] targ);
        return ((code == 4'd6) && (targ == 2'd1)) || ((code == 4'd7) && (targ == 2'd0));
    endfunction

endpackage

// File: rtl/nbm_in_if.sv
// ----------------------------------------------------------------------------
// nbm_in_if
// Template request channel: one template with its neighborhood per request.
// ----------------------------------------------------------------------------
interface nbm_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [nbm_pkg::CELLS_LO_W-1:0]       template_cells_low;
    logic [nbm_pkg::CELLS_HI_W-1:0]       template_cells_high;
    logic [nbm_pkg::LEVEL_W-1:0]          template_level;
    logic [nbm_pkg::PLANE_W-1:0]          presence_cells;
    logic [nbm_pkg::PLANE_W-1:0]          target_cells;
    logic                                 last_template;

    modport source (
        output valid, template_cells_low, template_cells_high, template_level,
        output presence_cells, target_cells, last_template,
        input  ready
    );

    modport sink (
        input  valid, template_cells_low, template_cells_high, template_level,
        input  presence_cells, target_cells, last_template,
        output ready
    );
endinterface

// File: rtl/nbm_out_if.sv
// ----------------------------------------------------------------------------
// nbm_out_if
// Result request channel: the best template of a run.
// ----------------------------------------------------------------------------
interface nbm_out_if;
    logic                                valid;
    logic                                ready;
    logic                                match_found;
    logic [nbm_pkg::INDEX_W-1:0]         best_index;
    logic signed [nbm_pkg::GAIN_W-1:0]   best_gain;

    modport source (
        output valid, match_found, best_index, best_gain,
        input  ready
    );

    modport sink (
        input  valid, match_found, best_index, best_gain,
        output ready
    );
endinterface

// File: rtl/nbm_cfg_if.sv
// ----------------------------------------------------------------------------
// nbm_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface nbm_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [nbm_pkg::CFG_ADDR_W-1:0]     addr;
    logic [nbm_pkg::CFG_DATA_W-1:0]     data;

    modport source (
        output valid, addr, data,
        input  ready
    );

    modport sink (
        input  valid, addr, data,
        output ready
    );
endinterface

// File: rtl/nbm_cell_eval.sv
// ----------------------------------------------------------------------------
// nbm_cell_eval
// Input register and cell evaluation stage: 27 table lookups, the all-pass
// match flag and the summed gain, registered for the selection stage.
// ----------------------------------------------------------------------------
module nbm_cell_eval (
    input  logic                  clk,
    input  logic                  rst_n,
    nbm_in_if.sink                templates,
    output logic                  eval_valid,
    input  logic                  eval_ready,
    output nbm_pkg::eval_t        eval_data
);

    logic                              s1_valid_reg;
    logic [nbm_pkg::CELLS_W-1:0]       s1_cells_reg;
    logic [nbm_pkg::LEVEL_W-1:0]       s1_level_reg;
    logic [nbm_pkg::PLANE_W-1:0]       s1_pres_reg;
    logic [nbm_pkg::PLANE_W-1:0]       s1_targ_reg;
    logic                              s1_last_reg;

    logic                              s2_valid_reg;
    nbm_pkg::eval_t                    s2_data_reg;
    nbm_pkg::eval_t                    s2_data_next;

    logic                              s2_free;
    logic                              s1_go;
    logic                              s1_free;
    logic [nbm_pkg::CELL_COUNT-1:0]    pass_vec;
    logic [nbm_pkg::CELL_COUNT-1:0]    up_vec;
    logic [nbm_pkg::CELL_COUNT-1:0]    down_vec;
    logic [nbm_pkg::CNT_W-1:0]         up_cnt;
    logic [nbm_pkg::CNT_W-1:0]         down_cnt;

    assign s2_free         = !s2_valid_reg || eval_ready;
    assign s1_go           = s1_valid_reg && s2_free;
    assign s1_free         = !s1_valid_reg || s2_free;
    assign templates.ready = s1_free;

    always_comb
    begin
        for (int i = 0; i < nbm_pkg::CELL_COUNT; i++)
        begin
            pass_vec[i] = nbm_pkg::cell_pass(s1_cells_reg[nbm_pkg::CODE_W*i +: nbm_pkg::CODE_W],
                                             s1_pres_reg[nbm_pkg::PRES_W*i +: nbm_pkg::PRES_W]);
            up_vec[i]   = nbm_pkg::cell_gain_up(
                              s1_cells_reg[nbm_pkg::CODE_W*i +: nbm_pkg::CODE_W],
                              s1_targ_reg[nbm_pkg::PRES_W*i +: nbm_pkg::PRES_W]);
            down_vec[i] = nbm_pkg::cell_gain_down(
                              s1_cells_reg[nbm_pkg::CODE_W*i +: nbm_pkg::CODE_W],
                              s1_targ_reg[nbm_pkg::PRES_W*i +: nbm_pkg::PRES_W]);
        end
    end

    assign up_cnt   = nbm_pkg::CNT_W'($countones(up_vec));
    assign down_cnt = nbm_pkg::CNT_W'($countones(down_vec));

    always_comb
    begin
        s2_data_next.match = &pass_vec;
        s2_data_next.gain  = $signed({1'b0, up_cnt}) - $signed({1'b0, down_cnt});
        s2_data_next.level = s1_level_reg;
        s2_data_next.last  = s1_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= templates.valid;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (templates.valid && s1_free)
        begin
            s1_cells_reg <= {templates.template_cells_high, templates.template_cells_low};
            s1_level_reg <= templates.template_level;
            s1_pres_reg  <= templates.presence_cells;
            s1_targ_reg  <= templates.target_cells;
            s1_last_reg  <= templates.last_template;
        end
        if (s1_go)
        begin
            s2_data_reg <= s2_data_next;
        end
    end

    assign eval_valid = s2_valid_reg;
    assign eval_data  = s2_data_reg;

endmodule

// File: rtl/nbm_selector.sv
// ----------------------------------------------------------------------------
// nbm_selector
// Running-best selection over a run of evaluated templates and the result
// register that holds the best template when the run closes.
// ----------------------------------------------------------------------------
module nbm_selector #(
    parameter int MAX_TEMPLATES = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [1:0]                      select_mode,
    input  logic [nbm_pkg::LEVEL_W-1:0]     level_split,
    input  logic                            eval_valid,
    output logic                            eval_ready,
    input  nbm_pkg::eval_t                  eval_data,
    nbm_out_if.source                       result
);

    localparam int POS_W = $clog2(MAX_TEMPLATES + 1);

    logic                               have_best_reg;
    logic [POS_W-1:0]                   best_pos_reg;
    logic [nbm_pkg::LEVEL_W-1:0]        best_level_reg;
    logic signed [nbm_pkg::GAIN_W-1:0]  best_gain_reg;
    logic [POS_W-1:0]                   run_pos_reg;
    logic                               split_seen_reg;

    logic                               have_best_next;
    logic [POS_W-1:0]                   best_pos_next;
    logic [nbm_pkg::LEVEL_W-1:0]        best_level_next;
    logic signed [nbm_pkg::GAIN_W-1:0]  best_gain_next;
    logic [POS_W-1:0]                   run_pos_next;
    logic                               split_seen_next;

    logic                               out_valid_reg;
    logic                               out_match_reg;
    logic [nbm_pkg::INDEX_W-1:0]        out_index_reg;
    logic signed [nbm_pkg::GAIN_W-1:0]  out_gain_reg;

    logic                               out_free;
    logic                               go;
    logic                               in_range;
    logic                               at_split;
    logic                               higher;
    logic                               take;
    logic signed [nbm_pkg::GAIN_W-1:0]  take_gain;
    logic [POS_W+nbm_pkg::INDEX_W-1:0]  pos_ext;

    assign out_free   = !out_valid_reg || result.ready;
    assign eval_ready = !eval_data.last || out_free;
    assign go         = eval_valid && eval_ready;

    assign in_range = run_pos_reg < POS_W'(MAX_TEMPLATES);
    assign at_split = eval_data.level >= level_split;
    assign higher   = !have_best_reg || (best_level_reg < eval_data.level);

    always_comb
    begin
        take      = 1'b0;
        take_gain = eval_data.gain;
        case (select_mode)
            nbm_pkg::MODE_LEVEL:
            begin
                take      = higher;
                take_gain = '0;
            end
            nbm_pkg::MODE_TARGET:
            begin
                take = !split_seen_reg && !at_split &&
                       (higher || (eval_data.gain >= best_gain_reg));
            end
            nbm_pkg::MODE_TRAIN:
            begin
                take = (split_seen_reg || at_split) &&
                       (higher || (eval_data.gain > best_gain_reg));
            end
            default:
            begin
                take = 1'b0;
            end
        endcase
        take = take && in_range && eval_data.match;
    end

    always_comb
    begin
        have_best_next  = have_best_reg;
        best_pos_next   = best_pos_reg;
        best_level_next = best_level_reg;
        best_gain_next  = best_gain_reg;
        split_seen_next = split_seen_reg || at_split;
        run_pos_next    = in_range ? run_pos_reg + POS_W'(1) : run_pos_reg;
        if (take)
        begin
            have_best_next  = 1'b1;
            best_pos_next   = run_pos_reg;
            best_level_next = eval_data.level;
            best_gain_next  = take_gain;
        end
    end

    assign pos_ext = {{nbm_pkg::INDEX_W{1'b0}}, best_pos_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_best_reg  <= 1'b0;
            best_pos_reg   <= '0;
            best_level_reg <= '0;
            best_gain_reg  <= -6'sd1;
            run_pos_reg    <= '0;
            split_seen_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (go)
            begin
                if (eval_data.last)
                begin
                    have_best_reg  <= 1'b0;
                    best_pos_reg   <= '0;
                    best_level_reg <= '0;
                    best_gain_reg  <= -6'sd1;
                    run_pos_reg    <= '0;
                    split_seen_reg <= 1'b0;
                end
                else
                begin
                    have_best_reg  <= have_best_next;
                    best_pos_reg   <= best_pos_next;
                    best_level_reg <= best_level_next;
                    best_gain_reg  <= best_gain_next;
                    run_pos_reg    <= run_pos_next;
                    split_seen_reg <= split_seen_next;
                end
            end
            if (go && eval_data.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && eval_data.last)
        begin
            out_match_reg <= have_best_next;
            out_index_reg <= have_best_next ? pos_ext[nbm_pkg::INDEX_W-1:0] : '0;
            out_gain_reg  <= best_gain_next;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.match_found = out_match_reg;
    assign result.best_index  = out_index_reg;
    assign result.best_gain   = out_gain_reg;

endmodule

// File: rtl/neighborhood_template_best_match_top.sv
// ----------------------------------------------------------------------------
// neighborhood_template_best_match_top
// Finds the best matching neighborhood template over a run of templates.
// ----------------------------------------------------------------------------
// The block accepts one template request per clock cycle unless the template
// input stalls, and keeps a running best across the run; a result request is
// offered only for the template marked last, once that template has passed the
// input register, the cell evaluation register and the result register. The
// selection stage compares each template against the held best combinationally.
// A template marked last waits in the cell evaluation register while the
// previous result has not been taken, and once the input register is also full
// the template input stalls. The select_mode and level_split registers must be
// written only while no run is in flight; the block does not enforce this.
module neighborhood_template_best_match_top #(
    parameter int MAX_TEMPLATES = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    nbm_cfg_if.sink    cfg,
    nbm_in_if.sink     templates,
    nbm_out_if.source  result
);

    logic [1:0]                    select_mode_reg;
    logic [nbm_pkg::LEVEL_W-1:0]   level_split_reg;
    logic                          eval_valid;
    logic                          eval_ready;
    nbm_pkg::eval_t                eval_data;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            select_mode_reg <= nbm_pkg::SELECT_MODE_RESET;
            level_split_reg <= nbm_pkg::LEVEL_SPLIT_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.addr)
                nbm_pkg::CFG_SELECT_MODE: select_mode_reg <= cfg.data[1:0];
                nbm_pkg::CFG_LEVEL_SPLIT: level_split_reg <= cfg.data;
                default:                  ;
            endcase
        end
    end

    nbm_cell_eval u_eval (
        .clk        (clk),
        .rst_n      (rst_n),
        .templates  (templates),
        .eval_valid (eval_valid),
        .eval_ready (eval_ready),
        .eval_data  (eval_data)
    );

    nbm_selector #(
        .MAX_TEMPLATES (MAX_TEMPLATES)
    ) u_selector (
        .clk         (clk),
        .rst_n       (rst_n),
        .select_mode (select_mode_reg),
        .level_split (level_split_reg),
        .eval_valid  (eval_valid),
        .eval_ready  (eval_ready),
        .eval_data   (eval_data),
        .result      (result)
    );

endmodule
